[rtl/rbs_pkg.sv]
// ----------------------------------------------------------------------------
// rbs_pkg: shared types, constants and preset tables
// Band tables, preset lookups and the lane control bundle used by the
// radio band selector and its lanes.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int unsigned BAND_COUNT = 3;

  // score arithmetic is 11-bit signed, wide enough for the blocked score
  localparam int unsigned SCORE_W = 11;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [7:0]         floor_t;
  typedef logic [1:0]                band_t;

  // region codes
  typedef enum logic [1:0] {
    RGN_AMER  = 2'd0,
    RGN_EU    = 2'd1,
    RGN_APAC  = 2'd2,
    RGN_WORLD = 2'd3
  } region_e;

  // terrain codes
  typedef enum logic [1:0] {
    TRN_CITY  = 2'd0,
    TRN_FIELD = 2'd1,
    TRN_WOODS = 2'd2,
    TRN_BLEND = 2'd3
  } terrain_e;

  // configuration register indexes
  typedef enum logic {
    CFG_REGION  = 1'b0,
    CFG_TERRAIN = 1'b1
  } cfg_idx_e;

  // band indexes
  localparam band_t BAND_433 = 2'd0;
  localparam band_t BAND_868 = 2'd1;
  localparam band_t BAND_915 = 2'd2;

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_BAND = 1'b1;

  localparam score_t SCORE_BLOCKED    = -11'sd1000;
  localparam floor_t FLOOR_RESET      = -8'sd120;
  localparam logic [6:0] LINK_GOOD    = 7'd50;
  localparam logic [6:0] BATTERY_LOW  = 7'd20;
  localparam score_t BONUS_OPEN       = 11'sd30;
  localparam score_t BONUS_URBAN      = 11'sd20;
  localparam score_t BONUS_LINK       = 11'sd15;
  localparam score_t PENALTY_HIGH_SF  = 11'sd10;
  localparam logic [3:0] SF_LIMIT     = 4'd9;

  // per-item controls shared by every lane
  typedef struct packed {
    region_e  region;
    terrain_e terrain;
    logic     battery_low;
    logic     link_good;
  } lane_ctrl_t;

  // one result item
  typedef struct packed {
    logic        status;
    band_t       band_index;
    logic [29:0] frequency_hz;
    logic [3:0]  spread_factor;
    logic [3:0]  coding_rate;
    logic [4:0]  tx_power_dbm;
  } result_t;

  // carrier frequency of a band
  function automatic logic [29:0] band_freq(band_t band);
    logic [29:0] f;
    case (band)
      BAND_433: f = 30'd433000000;
      BAND_868: f = 30'd868000000;
      BAND_915: f = 30'd915000000;
      default:  f = 30'd0;
    endcase
    return f;
  endfunction

  // band allowed in a region
  function automatic logic band_allowed(region_e region, band_t band);
    logic a;
    case (region)
      RGN_AMER:  a = (band == BAND_433) || (band == BAND_915);
      RGN_EU:    a = (band == BAND_433) || (band == BAND_868);
      RGN_APAC:  a = (band == BAND_433);
      RGN_WORLD: a = (band == BAND_433) || (band == BAND_868) ||
                     (band == BAND_915);
      default:   a = 1'b0;
    endcase
    return a;
  endfunction

  // transmit power ceiling per region and band
  function automatic logic [4:0] power_cap(region_e region, band_t band);
    logic [4:0] c;
    c = 5'd0;
    case (band)
      BAND_433: c = 5'd10;
      BAND_868: begin
        if (region == RGN_EU || region == RGN_WORLD) c = 5'd14;
      end
      BAND_915: begin
        if (region == RGN_AMER) c = 5'd30;
        else if (region == RGN_WORLD) c = 5'd20;
      end
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  // spreading factor of the terrain preset
  function automatic logic [3:0] preset_sf(terrain_e terrain, band_t band);
    logic [3:0] sf;
    case (terrain)
      TRN_CITY:  sf = 4'd8;
      TRN_FIELD: sf = (band == BAND_433) ? 4'd10 : 4'd9;
      TRN_WOODS: sf = (band == BAND_433) ? 4'd11 : 4'd10;
      TRN_BLEND: sf = 4'd9;
      default:   sf = 4'd0;
    endcase
    return sf;
  endfunction

  // coding rate denominator of the terrain preset
  function automatic logic [3:0] preset_cr(terrain_e terrain, band_t band);
    logic [3:0] cr;
    case (terrain)
      TRN_CITY:  cr = 4'd5;
      TRN_WOODS: cr = (band == BAND_433) ? 4'd7 : 4'd6;
      TRN_FIELD,
      TRN_BLEND: cr = 4'd6;
      default:   cr = 4'd0;
    endcase
    return cr;
  endfunction

  // transmit power of the terrain preset
  function automatic logic [4:0] preset_tx(terrain_e terrain, band_t band);
    logic [4:0] tx;
    case (terrain)
      TRN_CITY:  tx = 5'd12;
      TRN_FIELD,
      TRN_WOODS: tx = (band == BAND_868) ? 5'd14 : 5'd17;
      TRN_BLEND: tx = (band == BAND_868) ? 5'd12 : 5'd15;
      default:   tx = 5'd0;
    endcase
    return tx;
  endfunction

  // low battery penalty of five per band step
  function automatic score_t band_penalty(band_t band);
    score_t p;
    case (band)
      BAND_433: p = 11'sd0;
      BAND_868: p = 11'sd5;
      BAND_915: p = 11'sd10;
      default:  p = 11'sd15;
    endcase
    return p;
  endfunction

endpackage

[rtl/rbs_chan_if.sv]
// ----------------------------------------------------------------------------
// rbs_chan_if: valid/ready channels of the radio band selector
// Request channel with noise floors and link data, and result channel
// with the chosen band preset.
// ----------------------------------------------------------------------------
interface rbs_in_if;
  logic                valid;
  logic                ready;
  logic                noise_update;
  logic signed [7:0]   noise_low_band;
  logic signed [7:0]   noise_mid_band;
  logic signed [7:0]   noise_high_band;
  logic [6:0]          battery_percent;
  logic [6:0]          link_score;

  modport source (
    output valid, noise_update, noise_low_band, noise_mid_band,
           noise_high_band, battery_percent, link_score,
    input  ready
  );
  modport sink (
    input  valid, noise_update, noise_low_band, noise_mid_band,
           noise_high_band, battery_percent, link_score,
    output ready
  );
endinterface

interface rbs_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [1:0]  band_index;
  logic [29:0] frequency_hz;
  logic [3:0]  spread_factor;
  logic [3:0]  coding_rate;
  logic [4:0]  tx_power_dbm;

  modport source (
    output valid, status, band_index, frequency_hz, spread_factor,
           coding_rate, tx_power_dbm,
    input  ready
  );
  modport sink (
    input  valid, status, band_index, frequency_hz, spread_factor,
           coding_rate, tx_power_dbm,
    output ready
  );
endinterface

[rtl/rbs_lane.sv]
// ----------------------------------------------------------------------------
// rbs_lane: score of one band
// Forms the band score from its noise floor, battery, terrain, region
// and link quality in one combinational pass.
// ----------------------------------------------------------------------------
module rbs_lane (
  input  rbs_pkg::band_t      band_i,
  input  rbs_pkg::lane_ctrl_t ctrl_i,
  input  rbs_pkg::floor_t     floor_i,
  input  logic                is_current_i,
  output rbs_pkg::score_t     score_o
);

  logic signed [9:0] diff;
  logic signed [9:0] diff_adj;
  logic signed [9:0] half;
  rbs_pkg::score_t   s;

  // noise term: (reset floor - floor) / 2, truncated toward zero
  always_comb begin
    diff     = 10'(rbs_pkg::FLOOR_RESET) - 10'(floor_i);
    diff_adj = diff + signed'({9'd0, diff[9]});
    half     = diff_adj >>> 1;
  end

  // penalties and bonuses
  always_comb begin
    s = 11'(half);
    if (ctrl_i.battery_low) begin
      s = s - rbs_pkg::band_penalty(band_i);
      if (rbs_pkg::preset_sf(ctrl_i.terrain, band_i) > rbs_pkg::SF_LIMIT) begin
        s = s - rbs_pkg::PENALTY_HIGH_SF;
      end
    end
    case (ctrl_i.terrain)
      rbs_pkg::TRN_CITY: begin
        if (band_i != rbs_pkg::BAND_433) s = s + rbs_pkg::BONUS_URBAN;
      end
      rbs_pkg::TRN_FIELD, rbs_pkg::TRN_WOODS: begin
        if (band_i == rbs_pkg::BAND_433) s = s + rbs_pkg::BONUS_OPEN;
      end
      default: s = s;
    endcase
    if (is_current_i && ctrl_i.link_good) begin
      s = s + rbs_pkg::BONUS_LINK;
    end
    if (!rbs_pkg::band_allowed(ctrl_i.region, band_i)) begin
      s = rbs_pkg::SCORE_BLOCKED;
    end
    score_o = s;
  end

endmodule

[rtl/rbs_merge.sv]
// ----------------------------------------------------------------------------
// rbs_merge: best band selection and preset lookup
// Picks the first band with the highest score and builds the result
// item, with the transmit power clamped to the region ceiling.
// ----------------------------------------------------------------------------
module rbs_merge (
  input  rbs_pkg::score_t     score_i [rbs_pkg::BAND_COUNT],
  input  rbs_pkg::lane_ctrl_t ctrl_i,
  output rbs_pkg::result_t    result_o
);

  rbs_pkg::band_t  best;
  rbs_pkg::score_t best_score;
  logic [4:0]      tx;
  logic [4:0]      cap;

  // first highest score wins ties
  always_comb begin
    best       = rbs_pkg::BAND_433;
    best_score = score_i[0];
    if (score_i[1] > best_score) begin
      best       = rbs_pkg::BAND_868;
      best_score = score_i[1];
    end
    if (score_i[2] > best_score) begin
      best       = rbs_pkg::BAND_915;
      best_score = score_i[2];
    end
  end

  // preset lookup and power clamp
  always_comb begin
    tx  = rbs_pkg::preset_tx(ctrl_i.terrain, best);
    cap = rbs_pkg::power_cap(ctrl_i.region, best);
    if (tx > cap) tx = cap;
    if (best_score < 0) begin
      result_o        = '0;
      result_o.status = rbs_pkg::STATUS_NO_BAND;
    end else begin
      result_o.status        = rbs_pkg::STATUS_OK;
      result_o.band_index    = best;
      result_o.frequency_hz  = rbs_pkg::band_freq(best);
      result_o.spread_factor = rbs_pkg::preset_sf(ctrl_i.terrain, best);
      result_o.coding_rate   = rbs_pkg::preset_cr(ctrl_i.terrain, best);
      result_o.tx_power_dbm  = tx;
    end
  end

endmodule

[rtl/radio_band_selector.sv]
// ----------------------------------------------------------------------------
// radio_band_selector: three-band radio band chooser
// Three score lanes run side by side, a merge stage picks the winner and
// an output register holds the result until the sink takes it.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  in_i      in    valid / ready    noise update, three floors, battery, link
//  out_o     out   valid / ready    status, band, frequency, sf, cr, tx power
//  cfg       in    cfg_we_i         cfg_idx_i, cfg_wdata_i (region, terrain)
//
// One item per cycle; an item's result is in the output register in the cycle
// after its transfer. Scoring, selection and lookup are combinational, as the
// current band feeds back into the next item's link bonus.
// A new item is taken while the output register is empty or being drained.
// Reset clears the output valid, sets region and terrain to global/mixed,
// the noise floors to -120 dBm and the current band to 433 MHz.
// ----------------------------------------------------------------------------
module radio_band_selector (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [1:0]       cfg_wdata_i,
  rbs_in_if.sink           in_i,
  rbs_out_if.source        out_o
);

  rbs_pkg::region_e     region_q;
  rbs_pkg::terrain_e    terrain_q;
  rbs_pkg::floor_t      floor_q [rbs_pkg::BAND_COUNT];
  rbs_pkg::floor_t      floor_d [rbs_pkg::BAND_COUNT];
  rbs_pkg::band_t       cur_band_q;
  rbs_pkg::score_t      score [rbs_pkg::BAND_COUNT];
  rbs_pkg::lane_ctrl_t  ctrl;
  rbs_pkg::result_t     result_d;
  rbs_pkg::result_t     result_q;
  logic                 out_valid_q;
  logic                 in_xfer;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q  <= rbs_pkg::RGN_WORLD;
      terrain_q <= rbs_pkg::TRN_BLEND;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbs_pkg::CFG_REGION:  region_q  <= rbs_pkg::region_e'(cfg_wdata_i);
        rbs_pkg::CFG_TERRAIN: terrain_q <= rbs_pkg::terrain_e'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // input transfer
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  // floors seen by this item, the item's own update first
  always_comb begin
    if (in_i.noise_update) begin
      floor_d[0] = in_i.noise_low_band;
      floor_d[1] = in_i.noise_mid_band;
      floor_d[2] = in_i.noise_high_band;
    end else begin
      floor_d = floor_q;
    end
  end

  always_comb begin
    ctrl.region      = region_q;
    ctrl.terrain     = terrain_q;
    ctrl.battery_low = in_i.battery_percent < rbs_pkg::BATTERY_LOW;
    ctrl.link_good   = in_i.link_score > rbs_pkg::LINK_GOOD;
  end

  // score lanes
  for (genvar b = 0; b < rbs_pkg::BAND_COUNT; b++) begin : g_lane
    rbs_lane u_lane (
      .band_i       (rbs_pkg::band_t'(b)),
      .ctrl_i       (ctrl),
      .floor_i      (floor_d[b]),
      .is_current_i (cur_band_q == rbs_pkg::band_t'(b)),
      .score_o      (score[b])
    );
  end

  // merge stage
  rbs_merge u_merge (
    .score_i  (score),
    .ctrl_i   (ctrl),
    .result_o (result_d)
  );

  // stored floors and current band
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rbs_pkg::BAND_COUNT; i++) begin
        floor_q[i] <= rbs_pkg::FLOOR_RESET;
      end
      cur_band_q <= rbs_pkg::BAND_433;
    end else if (in_xfer) begin
      floor_q <= floor_d;
      if (result_d.status == rbs_pkg::STATUS_OK) begin
        cur_band_q <= result_d.band_index;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = result_q.status;
  assign out_o.band_index    = result_q.band_index;
  assign out_o.frequency_hz  = result_q.frequency_hz;
  assign out_o.spread_factor = result_q.spread_factor;
  assign out_o.coding_rate   = result_q.coding_rate;
  assign out_o.tx_power_dbm  = result_q.tx_power_dbm;

  // a chosen band becomes the current band
  a_cur_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (out_o.status == rbs_pkg::STATUS_NO_BAND) ||
                (cur_band_q == out_o.band_index))
    else $error("current band does not follow the chosen band");

  // a failure result carries no preset
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.status == rbs_pkg::STATUS_NO_BAND) |->
      (out_o.frequency_hz == 30'd0 && out_o.tx_power_dbm == 5'd0 &&
       out_o.band_index == rbs_pkg::BAND_433))
    else $error("failure result carries preset fields");

  // no band index beyond the three bands
  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_o.band_index != 2'd3))
    else $error("band index out of range");

  // an empty output register never blocks input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output register");

endmodule
